// ----- sv/fixed_slot_free_list_allocator_unit_defines.svh -----
// Assertion macros for the slot allocator; clk and rst_n are taken from the using scope.
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define FSFLA_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FSFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fsfla_pkg.sv -----
package fsfla_pkg;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF  = 1024;
  localparam int ADDR_W_DEF = 32;

  // Fixed field widths
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 4;
  localparam int IDX_OUT_W = 10;
  localparam int FREE_W    = 11;
  localparam int SHIFT_W   = 5;
  localparam int COUNT_W   = 11;
  localparam int CFG_IDX_W = 2;

  // Slot shift is clamped to this range
  localparam int SHIFT_MIN = 1;
  localparam int SHIFT_MAX = 16;

  // Register reset values
  localparam int SHIFT_RST = 6;
  localparam int COUNT_RST = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_REINIT  = 2'd3
  } fsfla_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED     = 4'd0,
    ST_EXT_ALLOC   = 4'd1,
    ST_RETURNED    = 4'd2,
    ST_EXT_FREE    = 4'd3,
    ST_NULL        = 4'd4,
    ST_KEPT        = 4'd5,
    ST_MOVE_OUT    = 4'd6,
    ST_EXT_REALLOC = 4'd7,
    ST_REINIT_DONE = 4'd8
  } fsfla_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE  = 2'd0,
    CFG_SLOT_SHIFT = 2'd1,
    CFG_SLOT_COUNT = 2'd2
  } fsfla_cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_LOOK,
    S_ACT,
    S_GRANT,
    S_RESULT
  } fsfla_state_t;

  typedef enum logic [1:0] {
    ASEL_ZERO,
    ASEL_GRANT,
    ASEL_KEEP
  } fsfla_asel_t;

  typedef enum logic [1:0] {
    ISEL_ZERO,
    ISEL_GRANT,
    ISEL_SLOT
  } fsfla_isel_t;

  // Controller to datapath
  typedef struct packed {
    logic          item_load;
    logic          pop;
    logic          push;
    logic          reinit;
    logic          pend_load;
    logic          grant_load;
    logic          res_load;
    fsfla_status_t status;
    fsfla_asel_t   addr_sel;
    fsfla_isel_t   idx_sel;
  } fsfla_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    fsfla_cmd_t cmd;
    logic       is_null;
    logic       in_heap;
    logic       fits;
    logic       empty;
    logic       out_free;
  } fsfla_stat_t;

endpackage

// ----- sv/fsfla_ctrl.sv -----
module fsfla_ctrl
  import fsfla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  fsfla_stat_t stat,
  output fsfla_ctrl_t ctrl
);

  fsfla_state_t state_r, state_nxt;
  logic         do_alloc;
  logic         alloc_ok;

  // Alloc path is shared by alloc and null realloc
  assign do_alloc = (stat.cmd == CMD_ALLOC) || ((stat.cmd == CMD_REALLOC) && stat.is_null);
  assign alloc_ok = !stat.empty && stat.fits;
  assign in_ready = (state_r == S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.item_load = 1'b1;
          state_nxt      = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_ACT;
      end
      S_ACT: begin
        ctrl.pend_load = 1'b1;
        ctrl.addr_sel  = ASEL_ZERO;
        ctrl.idx_sel   = ISEL_ZERO;
        state_nxt      = S_RESULT;
        if (do_alloc) begin
          if (alloc_ok) begin
            ctrl.pop      = 1'b1;
            ctrl.status   = ST_GRANTED;
            ctrl.addr_sel = ASEL_GRANT;
            ctrl.idx_sel  = ISEL_GRANT;
            state_nxt     = S_GRANT;
          end else begin
            ctrl.status = ST_EXT_ALLOC;
          end
        end else begin
          case (stat.cmd)
            CMD_FREE: begin
              if (stat.is_null) begin
                ctrl.status = ST_NULL;
              end else if (stat.in_heap) begin
                ctrl.push    = 1'b1;
                ctrl.status  = ST_RETURNED;
                ctrl.idx_sel = ISEL_SLOT;
              end else begin
                ctrl.status = ST_EXT_FREE;
              end
            end
            CMD_REALLOC: begin
              if (stat.in_heap && stat.fits) begin
                ctrl.status   = ST_KEPT;
                ctrl.addr_sel = ASEL_KEEP;
                ctrl.idx_sel  = ISEL_SLOT;
              end else if (stat.in_heap) begin
                ctrl.push    = 1'b1;
                ctrl.status  = ST_MOVE_OUT;
                ctrl.idx_sel = ISEL_SLOT;
              end else begin
                ctrl.status = ST_EXT_REALLOC;
              end
            end
            CMD_REINIT: begin
              ctrl.reinit = 1'b1;
              ctrl.status = ST_REINIT_DONE;
            end
            default: begin
              ctrl.status = ST_EXT_ALLOC;
            end
          endcase
        end
      end
      S_GRANT: begin
        ctrl.grant_load = 1'b1;
        state_nxt       = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          ctrl.res_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/fsfla_dp.sv -----
module fsfla_dp
  import fsfla_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int ADDR_W = ADDR_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [DATA_W-1:0]    in_req_bytes,
  input  logic [DATA_W-1:0]    in_buffer_address,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [DATA_W-1:0]    out_result_address,
  output logic [IDX_OUT_W-1:0] out_slot_index,
  output logic [FREE_W-1:0]    out_free_slots,
  input  fsfla_ctrl_t          ctrl,
  output fsfla_stat_t          stat
);

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOP_W   = $clog2(SLOTS + 1);
  localparam int BYTES_W = DATA_W + 1;

  // Configuration registers
  logic [DATA_W-1:0]  heap_base_r;
  logic [SHIFT_W-1:0] slot_shift_r;
  logic [COUNT_W-1:0] slot_count_r;

  // Clamped configuration
  logic [SHIFT_W-1:0] eff_shift;
  logic [TOP_W-1:0]   eff_count;

  // Item registers
  fsfla_cmd_t         cmd_r;
  logic [DATA_W-1:0]  bytes_r;
  logic [ADDR_W-1:0]  buf_r;

  // Address decode stages
  logic [ADDR_W-1:0]  off_r;
  logic               fits_r;
  logic               null_r;
  logic [ADDR_W-1:0]  slot_wide;
  logic               inside_r;
  logic [IDX_W-1:0]   slot_r;

  // Free stack
  logic [IDX_W-1:0]   stack_mem [SLOTS];
  logic [TOP_W-1:0]   top_r;
  logic [TOP_W-1:0]   mark_r;
  logic [TOP_W-1:0]   top_dec;
  logic               full;
  logic [IDX_W-1:0]   rd_data_r;
  logic               use_ident_r;
  logic [IDX_W-1:0]   ident_r;

  // Grant
  logic [IDX_W-1:0]   grant_idx;
  logic [IDX_W-1:0]   grant_idx_r;
  logic [ADDR_W-1:0]  grant_addr_r;

  // Pending result
  fsfla_status_t      pend_status_r;
  fsfla_asel_t        pend_asel_r;
  fsfla_isel_t        pend_isel_r;
  logic [DATA_W-1:0]  res_addr;
  logic [IDX_OUT_W-1:0] res_idx;

  // Output register
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [DATA_W-1:0]    out_addr_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [FREE_W-1:0]    out_free_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= '0;
      slot_shift_r <= SHIFT_W'(SHIFT_RST);
      slot_count_r <= COUNT_W'(COUNT_RST);
    end else if (cfg_we) begin
      case (fsfla_cfg_reg_t'(cfg_index))
        CFG_HEAP_BASE:  heap_base_r  <= cfg_data;
        CFG_SLOT_SHIFT: slot_shift_r <= cfg_data[SHIFT_W-1:0];
        CFG_SLOT_COUNT: slot_count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp shift and count
  always_comb begin
    if (slot_shift_r < SHIFT_W'(SHIFT_MIN)) begin
      eff_shift = SHIFT_W'(SHIFT_MIN);
    end else if (slot_shift_r > SHIFT_W'(SHIFT_MAX)) begin
      eff_shift = SHIFT_W'(SHIFT_MAX);
    end else begin
      eff_shift = slot_shift_r;
    end
  end

  assign eff_count = (32'(slot_count_r) > 32'(SLOTS)) ? TOP_W'(SLOTS) : TOP_W'(slot_count_r);

  // Capture the word
  always_ff @(posedge clk) begin
    if (ctrl.item_load) begin
      cmd_r   <= fsfla_cmd_t'(in_cmd);
      bytes_r <= in_req_bytes;
      buf_r   <= ADDR_W'(in_buffer_address);
    end
  end

  // Offset, size fit and null test
  always_ff @(posedge clk) begin
    off_r  <= buf_r - ADDR_W'(heap_base_r);
    fits_r <= BYTES_W'(bytes_r) <= (BYTES_W'(1) << eff_shift);
    null_r <= (buf_r == '0);
  end

  // Slot number and range check
  assign slot_wide = off_r >> eff_shift;

  always_ff @(posedge clk) begin
    inside_r <= 64'(slot_wide) < 64'(eff_count);
    slot_r   <= IDX_W'(slot_wide);
  end

  // Stack pointer; entries below mark_r still hold their own index
  assign top_dec = top_r - TOP_W'(1);
  assign full    = (32'(top_r) >= 32'(SLOTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= TOP_W'(SLOTS);
      mark_r <= TOP_W'(SLOTS);
    end else if (ctrl.reinit) begin
      top_r  <= eff_count;
      mark_r <= eff_count;
    end else if (ctrl.pop) begin
      top_r <= top_dec;
      if (mark_r == top_r) begin
        mark_r <= top_dec;
      end
    end else if (ctrl.push && !full) begin
      top_r <= top_r + TOP_W'(1);
    end
  end

  // Stack memory, registered read
  always_ff @(posedge clk) begin
    if (ctrl.push && !full) begin
      stack_mem[top_r[IDX_W-1:0]] <= slot_r;
    end
    if (ctrl.pop) begin
      rd_data_r   <= stack_mem[top_dec[IDX_W-1:0]];
      use_ident_r <= (top_r == mark_r);
      ident_r     <= top_dec[IDX_W-1:0];
    end
  end

  // Granted slot and its address
  assign grant_idx = use_ident_r ? ident_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (ctrl.grant_load) begin
      grant_idx_r  <= grant_idx;
      grant_addr_r <= ADDR_W'(heap_base_r) + (ADDR_W'(grant_idx) << eff_shift);
    end
  end

  // Decision held until the result slot frees
  always_ff @(posedge clk) begin
    if (ctrl.pend_load) begin
      pend_status_r <= ctrl.status;
      pend_asel_r   <= ctrl.addr_sel;
      pend_isel_r   <= ctrl.idx_sel;
    end
  end

  // Result field selection
  always_comb begin
    case (pend_asel_r)
      ASEL_GRANT: res_addr = DATA_W'(grant_addr_r);
      ASEL_KEEP:  res_addr = DATA_W'(buf_r);
      default:    res_addr = '0;
    endcase
    case (pend_isel_r)
      ISEL_GRANT: res_idx = IDX_OUT_W'(grant_idx_r);
      ISEL_SLOT:  res_idx = IDX_OUT_W'(slot_r);
      default:    res_idx = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      out_status_r <= pend_status_r;
      out_addr_r   <= res_addr;
      out_idx_r    <= res_idx;
      out_free_r   <= FREE_W'(top_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;
  assign out_slot_index     = out_idx_r;
  assign out_free_slots     = out_free_r;

  // Status back to the controller
  assign stat.cmd      = cmd_r;
  assign stat.is_null  = null_r;
  assign stat.in_heap  = inside_r;
  assign stat.fits     = fits_r;
  assign stat.empty    = (top_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

// ----- sv/fixed_slot_free_list_allocator_unit.sv -----
// Channel   Handshake               Word
// in        in_valid / in_ready     in_cmd, in_req_bytes, in_buffer_address
// out       out_valid / out_ready   out_status, out_result_address, out_slot_index,
//                                   out_free_slots
// cfg       cfg_we                  cfg_index, cfg_data
//
// One word at a time: a word is accepted only once the last word's result is loaded;
// a granted alloc also passes the grant state (registered stack read, then the
// base-plus-shift address add). A mark register makes entries below it read as
// their own index, so neither reset nor reinit sweeps the stack memory.
// Reset is synchronous on rst_n. A stalled out channel holds the controller in
// its result state; the next word may still be accepted while a result waits.
`include "fixed_slot_free_list_allocator_unit_defines.svh"

module fixed_slot_free_list_allocator_unit
  import fsfla_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int ADDR_W = ADDR_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [DATA_W-1:0]    in_req_bytes,
  input  logic [DATA_W-1:0]    in_buffer_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [DATA_W-1:0]    out_result_address,
  output logic [IDX_OUT_W-1:0] out_slot_index,
  output logic [FREE_W-1:0]    out_free_slots
);

  fsfla_ctrl_t ctrl;
  fsfla_stat_t stat;

  // Sequencer
  fsfla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Address decode, free stack and result register
  fsfla_dp #(
    .SLOTS  (SLOTS),
    .ADDR_W (ADDR_W)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_cmd             (in_cmd),
    .in_req_bytes       (in_req_bytes),
    .in_buffer_address  (in_buffer_address),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_slot_index     (out_slot_index),
    .out_free_slots     (out_free_slots),
    .ctrl               (ctrl),
    .stat               (stat)
  );

  // Checks
  `FSFLA_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready, "second word taken while busy")
  `FSFLA_ASSERT_HOLD(a_res_free, ctrl.res_load, !out_valid || out_ready, "result overwritten")
  `FSFLA_ASSERT_HOLD(a_pop_ok, ctrl.pop, !ctrl.push && !ctrl.reinit && !stat.empty, "bad pop")
  `FSFLA_ASSERT_HOLD(a_grant_cnt, out_valid && (out_status == ST_GRANTED), 32'(out_free_slots) < SLOTS, "grant with full stack")

endmodule
